[rtl/lru_object_cache_directory_top_defines.svh]
// Assertion macros for the LRU object cache directory.
`ifndef LRU_OBJECT_CACHE_DIRECTORY_TOP_DEFINES_SVH
`define LRU_OBJECT_CACHE_DIRECTORY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LOCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LOCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/locd_pkg.sv]
// Shared types and constants of the LRU object cache directory.
package locd_pkg;

  localparam int LINES_DEF    = 16;
  localparam int AGE_BITS_DEF = 16;

  localparam int KEY_W    = 64;
  localparam int SIZE_W   = 17;
  localparam int STATUS_W = 2;
  localparam int LINE_W   = 4;
  localparam int OCC_W    = 5;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  localparam logic [SIZE_W-1:0] MAX_OBJECT_SIZE_RST = 17'd102400;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic REG_MAX_OBJECT_SIZE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_RD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic reduce;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic need_victim;
  } sts_t;

endpackage

[rtl/locd_ram.sv]
// Generic simple dual-port RAM with registered read.
module locd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/locd_ctrl.sv]
// Request sequencer of the LRU object cache directory.
module locd_ctrl #(
  parameter int LINES = locd_pkg::LINES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  locd_pkg::sts_t sts,
  output locd_pkg::cmd_t cmd
);

  localparam int LEVELS = $clog2(LINES);
  localparam int LCW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  locd_pkg::state_t state, state_next;
  logic [LCW-1:0]   lvl, lvl_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= locd_pkg::S_IDLE;
      lvl       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      locd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = locd_pkg::S_CMP;
        end
      end
      locd_pkg::S_CMP: begin
        cmd.compare = 1'b1;
        lvl_next    = '0;
        if (sts.need_victim && (LEVELS > 0)) begin
          state_next = locd_pkg::S_SEL;
        end else begin
          state_next = locd_pkg::S_RD;
        end
      end
      locd_pkg::S_SEL: begin
        cmd.reduce = 1'b1;
        lvl_next   = lvl + 1'b1;
        if (lvl == LCW'(LEVELS - 1)) begin
          state_next = locd_pkg::S_RD;
        end
      end
      locd_pkg::S_RD: begin
        state_next = locd_pkg::S_DONE;
      end
      locd_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = locd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = locd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/locd_datapath.sv]
// Line directory, key compare, victim select, age update and result register.
module locd_datapath #(
  parameter int LINES    = locd_pkg::LINES_DEF,
  parameter int AGE_BITS = locd_pkg::AGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  locd_pkg::cmd_t                    cmd,
  output locd_pkg::sts_t                    sts,
  input  logic                              in_func,
  input  logic [locd_pkg::KEY_W-1:0]        in_key,
  input  logic [locd_pkg::SIZE_W-1:0]       in_size,
  input  logic [locd_pkg::SIZE_W-1:0]       max_size,
  output logic [locd_pkg::STATUS_W-1:0]     out_status,
  output logic [locd_pkg::LINE_W-1:0]       out_line,
  output logic [locd_pkg::SIZE_W-1:0]       out_size,
  output logic [locd_pkg::OCC_W-1:0]        out_occ,
  output logic [$clog2(LINES+1)-1:0]        count
);

  localparam int IW  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW  = $clog2(LINES + 1);
  localparam int LP2 = 2 ** $clog2(LINES);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [LINES-1:0]                valid;
  logic [locd_pkg::KEY_W-1:0]      keys [LINES];
  logic [AGE_BITS-1:0]             ages [LINES];

  logic                            req_func;
  logic [locd_pkg::KEY_W-1:0]      req_key;
  logic [locd_pkg::SIZE_W-1:0]     req_size;

  logic                            hit_c, empty_c, size_ok_c;
  logic [IW-1:0]                   hit_idx_c, empty_idx_c;
  logic                            hit_r, empty_r, size_ok_r;
  logic [IW-1:0]                   hit_idx_r, empty_idx_r;

  logic [AGE_BITS-1:0]             red_age [LP2];
  logic [IW-1:0]                   red_idx [LP2];

  logic [locd_pkg::SIZE_W-1:0]     ram_rdata;
  logic                            is_insert, accepted, touch, grows;
  logic [IW-1:0]                   wr_idx, t_idx;
  logic [CW-1:0]                   count_next;
  locd_pkg::status_t               status_c;
  logic [locd_pkg::SIZE_W-1:0]     size_c;
  logic [IW+locd_pkg::LINE_W-1:0]  line_ext;
  logic [CW+locd_pkg::OCC_W-1:0]   occ_ext;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func <= in_func;
      req_key  <= in_key;
      req_size <= in_size;
    end
  end

  // key match and first free line, lowest index wins
  always_comb begin
    hit_c       = 1'b0;
    hit_idx_c   = '0;
    empty_c     = 1'b0;
    empty_idx_c = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (valid[i] && (keys[i] == req_key)) begin
        hit_c     = 1'b1;
        hit_idx_c = IW'(i);
      end
      if (!valid[i]) begin
        empty_c     = 1'b1;
        empty_idx_c = IW'(i);
      end
    end
    size_ok_c       = (req_size <= max_size);
    sts.need_victim = (req_func == locd_pkg::FUNC_INSERT) && size_ok_c && !hit_c && !empty_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r       <= hit_c;
      hit_idx_r   <= hit_idx_c;
      empty_r     <= empty_c;
      empty_idx_r <= empty_idx_c;
      size_ok_r   <= size_ok_c;
    end
  end

  // oldest-line tree, one level per cycle; strict compare keeps lower index on a tie
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < LP2; i++) begin
        red_age[i] <= (i < LINES) ? ages[i] : '0;
        red_idx[i] <= IW'(i);
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < LP2 / 2; i++) begin
        if (red_age[2*i+1] > red_age[2*i]) begin
          red_age[i] <= red_age[2*i+1];
          red_idx[i] <= red_idx[2*i+1];
        end else begin
          red_age[i] <= red_age[2*i];
          red_idx[i] <= red_idx[2*i];
        end
      end
    end
  end

  // commit
  always_comb begin
    is_insert = (req_func == locd_pkg::FUNC_INSERT);
    accepted  = is_insert && size_ok_r;
    touch     = accepted || (!is_insert && hit_r);
    wr_idx    = hit_r ? hit_idx_r : (empty_r ? empty_idx_r : red_idx[0]);
    t_idx     = is_insert ? wr_idx : hit_idx_r;
    grows     = accepted && !valid[wr_idx];
    count_next = count + CW'(grows);
    if (is_insert) begin
      status_c = size_ok_r ? locd_pkg::ST_INSERTED : locd_pkg::ST_REJECTED;
      size_c   = size_ok_r ? req_size : '0;
    end else begin
      status_c = hit_r ? locd_pkg::ST_HIT : locd_pkg::ST_MISS;
      size_c   = hit_r ? ram_rdata : '0;
    end
    line_ext = {{locd_pkg::LINE_W{1'b0}}, (touch ? t_idx : {IW{1'b0}})};
    occ_ext  = {{locd_pkg::OCC_W{1'b0}}, count_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < LINES; i++) begin
        ages[i] <= '0;
      end
    end else if (cmd.update) begin
      count <= count_next;
      if (accepted) begin
        valid[wr_idx] <= 1'b1;
      end
      if (touch) begin
        for (int i = 0; i < LINES; i++) begin
          if (t_idx == IW'(i)) begin
            ages[i] <= '0;
          end else if (valid[i] && (ages[i] != AGE_MAX)) begin
            ages[i] <= ages[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && accepted) begin
      keys[wr_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_status <= status_c;
      out_line   <= line_ext[locd_pkg::LINE_W-1:0];
      out_size   <= size_c;
      out_occ    <= occ_ext[locd_pkg::OCC_W-1:0];
    end
  end

  locd_ram #(
    .WIDTH (locd_pkg::SIZE_W),
    .DEPTH (LINES)
  ) u_size_ram (
    .clk   (clk),
    .we    (cmd.update && accepted),
    .waddr (wr_idx),
    .wdata (req_size),
    .raddr (hit_idx_r),
    .rdata (ram_rdata)
  );

endmodule

[rtl/lru_object_cache_directory_top.sv]
// Top level of the LRU object cache directory.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser func, tdata key/obj_size
//  m_axis    out  tvalid/tready             tuser status, tdata line/size/occupancy
//  apb       in   psel/penable/pwrite       paddr, pwdata, prdata
//
// One request at a time: lookups, hits and inserts with a free or matching line
// pass through capture, compare, read and done; an insert that evicts also walks
// the oldest-line compare tree. Key match is a parallel compare over all lines.
// Sync reset clears valid bits, ages and occupancy.
// The result register holds while m_axis_tready is low; the next request is
// taken meanwhile and waits in its final step for the register to free.
`include "lru_object_cache_directory_top_defines.svh"

module lru_object_cache_directory_top #(
  parameter int LINES    = locd_pkg::LINES_DEF,
  parameter int AGE_BITS = locd_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] key, [80:64] obj_size, [87:81] zero
  input  logic [locd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [3:0] line, [20:4] stored_size, [25:21] occupancy, [31:26] zero
  output logic [locd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [locd_pkg::STATUS_W-1:0]       m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  locd_pkg::cmd_t                    cmd;
  locd_pkg::sts_t                    sts;
  logic [locd_pkg::SIZE_W-1:0]       max_size;
  logic [locd_pkg::LINE_W-1:0]       out_line;
  logic [locd_pkg::SIZE_W-1:0]       out_size;
  logic [locd_pkg::OCC_W-1:0]        out_occ;
  logic [$clog2(LINES+1)-1:0]        count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == locd_pkg::REG_MAX_OBJECT_SIZE) ?
                  {{(32 - locd_pkg::SIZE_W){1'b0}}, max_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= locd_pkg::MAX_OBJECT_SIZE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == locd_pkg::REG_MAX_OBJECT_SIZE)) begin
      max_size <= pwdata[locd_pkg::SIZE_W-1:0];
    end
  end

  locd_ctrl #(
    .LINES (LINES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  locd_datapath #(
    .LINES    (LINES),
    .AGE_BITS (AGE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (s_axis_tuser),
    .in_key     (s_axis_tdata[locd_pkg::KEY_W-1:0]),
    .in_size    (s_axis_tdata[locd_pkg::KEY_W+locd_pkg::SIZE_W-1:locd_pkg::KEY_W]),
    .max_size   (max_size),
    .out_status (m_axis_tuser),
    .out_line   (out_line),
    .out_size   (out_size),
    .out_occ    (out_occ),
    .count      (count)
  );

  assign m_axis_tdata = {{(locd_pkg::OUT_DATA_W - locd_pkg::LINE_W - locd_pkg::SIZE_W
                           - locd_pkg::OCC_W){1'b0}}, out_occ, out_size, out_line};

  `LOCD_ASSERT_IMP(a_count_bound, 1'b1, count <= ($clog2(LINES+1))'(LINES), "occupancy above line count")
  `LOCD_ASSERT_NXT(a_count_mono, 1'b1, count >= $past(count), "occupancy decreased")
  `LOCD_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second transaction taken while busy")
  `LOCD_ASSERT_IMP(a_miss_zero, m_axis_tvalid && (m_axis_tuser == locd_pkg::ST_MISS || m_axis_tuser == locd_pkg::ST_REJECTED), m_axis_tdata[locd_pkg::LINE_W+locd_pkg::SIZE_W-1:0] == '0, "miss or reject with nonzero line or size")

endmodule

[verif/tb_lru_object_cache_directory_top.sv]
// Testbench for the LRU object cache directory: directed and random requests vs a predictor.
`timescale 1ns / 100ps

module tb_lru_object_cache_directory_top;

  localparam int NLINES     = locd_pkg::LINES_DEF;
  localparam int KEY_W      = locd_pkg::KEY_W;
  localparam int SIZE_W     = locd_pkg::SIZE_W;
  localparam int LINE_W     = locd_pkg::LINE_W;
  localparam int OCC_W      = locd_pkg::OCC_W;
  localparam int IN_DATA_W  = locd_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = locd_pkg::OUT_DATA_W;
  localparam int STATUS_W   = locd_pkg::STATUS_W;
  localparam int AGE_W      = locd_pkg::AGE_BITS_DEF;
  localparam int PAD_IN     = IN_DATA_W - KEY_W - SIZE_W;
  localparam logic [AGE_W-1:0] AGE_SAT = '1;
  localparam logic [SIZE_W-1:0] SIZE_ALL = '1;
  localparam logic [SIZE_W-1:0] SIZE_RST = locd_pkg::MAX_OBJECT_SIZE_RST;
  localparam logic [2:0] ADDR_MAX_OBJECT_SIZE = 3'(4 * locd_pkg::REG_MAX_OBJECT_SIZE);
  localparam logic [2:0] ADDR_UNMAPPED = ADDR_MAX_OBJECT_SIZE + 3'd4;
  localparam int HOLD_CYCLES = 400;
  localparam int HOT_LOOKUPS = 20;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } dir_req_t;

  typedef struct packed {
    locd_pkg::status_t status;
    logic [LINE_W-1:0] line;
    logic [SIZE_W-1:0] size;
    logic [OCC_W-1:0]  occ;
  } dir_res_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0]      m_axis_tuser;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  // predictor state
  logic                     dir_valid [NLINES];
  logic [KEY_W-1:0]         dir_key   [NLINES];
  logic [AGE_W-1:0]         dir_age   [NLINES];
  logic [SIZE_W-1:0]        dir_size  [NLINES];
  int                       dir_count;
  logic [SIZE_W-1:0]        size_limit = SIZE_RST;

  dir_req_t pending_requests[$];
  dir_res_t predicted_responses[$];
  dir_req_t in_flight;

  int  n_queued = 0, n_accepted = 0, n_checked = 0, errors = 0;
  int  n_hits = 0, n_misses = 0, n_inserts = 0, n_rejects = 0, n_evicts = 0;
  int  n_limits = 0;
  int  src_gap = 0, sink_gap = 0, long_hold = 0;
  bit  src_idle_ok = 1'b0, sink_idle_ok = 1'b0;
  bit  stall_req = 1'b0, stall_taken = 1'b0;

  lru_object_cache_directory_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    for (int i = 0; i < NLINES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_age[i]   = '0;
      dir_size[i]  = '0;
    end
    dir_count = 0;
  end

  function automatic void age_and_touch(int w);
    for (int i = 0; i < NLINES; i++)
      if (dir_valid[i] && dir_age[i] != AGE_SAT) dir_age[i]++;
    dir_age[w] = '0;
  endfunction

  function automatic dir_res_t predict_request(dir_req_t r);
    dir_res_t res;
    int hit, w;
    hit = -1;
    res = '0;
    for (int i = 0; i < NLINES; i++)
      if (hit < 0 && dir_valid[i] && dir_key[i] == r.key) hit = i;
    if (r.func == locd_pkg::FUNC_LOOKUP) begin
      if (hit >= 0) begin
        res.status = locd_pkg::ST_HIT;
        res.line   = hit[LINE_W-1:0];
        res.size   = dir_size[hit];
        age_and_touch(hit);
        n_hits++;
      end else begin
        res.status = locd_pkg::ST_MISS;
        n_misses++;
      end
    end else if (r.size > size_limit) begin
      res.status = locd_pkg::ST_REJECTED;
      n_rejects++;
    end else begin
      w = hit;
      if (w < 0) begin
        for (int i = 0; i < NLINES; i++)
          if (w < 0 && !dir_valid[i]) w = i;
        if (w < 0) begin
          // oldest line, lowest index on a tie
          w = 0;
          for (int i = 1; i < NLINES; i++)
            if (dir_age[i] > dir_age[w]) w = i;
          n_evicts++;
        end else begin
          dir_count++;
        end
      end
      dir_valid[w] = 1'b1;
      dir_key[w]   = r.key;
      dir_size[w]  = r.size;
      age_and_touch(w);
      res.status = locd_pkg::ST_INSERTED;
      res.line   = w[LINE_W-1:0];
      res.size   = r.size;
      n_inserts++;
    end
    res.occ = dir_count[OCC_W-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_responses.push_back(predict_request(in_flight));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_flight = pending_requests.pop_front();
          s_axis_tdata  <= {{PAD_IN{1'b0}}, in_flight.size, in_flight.key};
          s_axis_tuser  <= in_flight.func;
          s_axis_tvalid <= 1'b1;
          if (src_idle_ok && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 6);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dir_res_t exp_res;
    logic [LINE_W-1:0] got_line;
    logic [SIZE_W-1:0] got_size;
    logic [OCC_W-1:0]  got_occ;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
      long_hold     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_line = m_axis_tdata[LINE_W-1:0];
        got_size = m_axis_tdata[LINE_W +: SIZE_W];
        got_occ  = m_axis_tdata[LINE_W+SIZE_W +: OCC_W];
        if (predicted_responses.size() == 0) begin
          $display("%0t: unexpected transaction status %0d line %0d size %0d occ %0d",
                   $time, m_axis_tuser, got_line, got_size, got_occ);
          errors++;
        end else begin
          exp_res = predicted_responses.pop_front();
          n_checked++;
          if (m_axis_tuser != exp_res.status || got_line != exp_res.line ||
              got_size != exp_res.size || got_occ != exp_res.occ) begin
            $display(
              "%0t: expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d (status/line/size/occ)",
              $time, exp_res.status, exp_res.line, exp_res.size, exp_res.occ,
              m_axis_tuser, got_line, got_size, got_occ);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold     <= long_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_req && !stall_taken) begin
        stall_taken   <= 1'b1;
        long_hold     <= HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_ok && $urandom_range(0, 4) == 0) begin
        sink_gap      <= $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_req(logic func, logic [KEY_W-1:0] key,
                                    logic [SIZE_W-1:0] size);
    dir_req_t r;
    r.func = func;
    r.key  = key;
    r.size = size;
    pending_requests.push_back(r);
    n_queued++;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return size_limit;
      1: return (size_limit == SIZE_ALL) ? size_limit
                : SIZE_W'(size_limit + 1 + $urandom_range(0, SIZE_ALL - size_limit - 1));
      2: return SIZE_W'($urandom_range(0, SIZE_ALL));
      default: return SIZE_W'($urandom_range(0, size_limit));
    endcase
  endfunction

  // inserts and lookups, keys mostly from a pool a bit larger than the directory
  task automatic queue_random(int n, int pool_n);
    logic [KEY_W-1:0] pool[32];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < 32; i++) pool[i] = rand_key();
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 9) == 0) ? rand_key() : pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 9) < 5) queue_req(locd_pkg::FUNC_INSERT, k, rand_size());
      else queue_req(locd_pkg::FUNC_LOOKUP, k, SIZE_W'($urandom_range(0, SIZE_ALL)));
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || predicted_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_OBJECT_SIZE) begin
      size_limit = data[SIZE_W-1:0];
      n_limits++;
    end
  endtask

  initial begin
    logic [KEY_W-1:0] hot_keys[NLINES];
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty miss, limit edges, hits, overwrite, fill and evict
    src_idle_ok  = 1'b1;
    sink_idle_ok = 1'b1;
    queue_req(locd_pkg::FUNC_LOOKUP, '0, SIZE_ALL);
    queue_req(locd_pkg::FUNC_INSERT, '1, SIZE_RST);
    queue_req(locd_pkg::FUNC_INSERT, '0, '0);
    queue_req(locd_pkg::FUNC_INSERT, 64'h1, SIZE_W'(SIZE_RST + 1));
    queue_req(locd_pkg::FUNC_INSERT, 64'h2, SIZE_ALL);
    queue_req(locd_pkg::FUNC_LOOKUP, '1, '0);
    queue_req(locd_pkg::FUNC_LOOKUP, '0, 17'h15555);
    queue_req(locd_pkg::FUNC_INSERT, '1, 17'd5);
    queue_req(locd_pkg::FUNC_LOOKUP, 64'h1, '0);
    for (int i = 0; i < NLINES - 2; i++)
      queue_req(locd_pkg::FUNC_INSERT, 64'h1 << (i + 4),
                SIZE_W'($urandom_range(0, SIZE_RST)));
    queue_req(locd_pkg::FUNC_INSERT, 64'hA5A5_5A5A_F00F_0FF0, 17'h0AAAA);
    queue_req(locd_pkg::FUNC_LOOKUP, '1, '0);
    wait_drained();

    apb_write(ADDR_UNMAPPED, 32'd7);
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'd0);
    queue_random(80, 24);
    wait_drained();

    // long receiver stall with the sender still offering
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'(SIZE_ALL));
    src_idle_ok = 1'b0;
    stall_req   = 1'b1;
    queue_random(100, 20);
    wait_drained();

    src_idle_ok  = 1'b1;
    sink_idle_ok = 1'b0;
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'($urandom_range(0, SIZE_ALL)));
    queue_random(200, 28);
    wait_drained();

    sink_idle_ok = 1'b1;
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'd1);
    queue_random(60, 18);
    wait_drained();

    src_idle_ok = 1'b0;
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'($urandom_range(0, SIZE_ALL)));
    queue_random(200, 24);
    wait_drained();

    src_idle_ok = 1'b1;
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'(SIZE_RST));
    queue_random(100, 32);
    wait_drained();

    // one line kept hot while the others age, then evictions pick the oldest
    src_idle_ok  = 1'b0;
    sink_idle_ok = 1'b0;
    apb_write(ADDR_MAX_OBJECT_SIZE, 32'(SIZE_ALL));
    for (int i = 0; i < NLINES; i++) begin
      hot_keys[i] = rand_key();
      queue_req(locd_pkg::FUNC_INSERT, hot_keys[i], SIZE_W'($urandom_range(0, SIZE_ALL)));
    end
    for (int i = 0; i < HOT_LOOKUPS; i++)
      queue_req(locd_pkg::FUNC_LOOKUP, hot_keys[NLINES-1], '0);
    for (int i = 0; i < 3; i++) queue_req(locd_pkg::FUNC_INSERT, rand_key(), rand_size());
    for (int i = 0; i < NLINES; i++) queue_req(locd_pkg::FUNC_LOOKUP, hot_keys[i], '0);
    wait_drained();

    repeat (20) @(posedge clk);
    errors += predicted_responses.size();
    $display("Checked %0d transactions over %0d size limits: %0d hits, %0d misses",
             n_checked, n_limits, n_hits, n_misses);
    $display("  %0d inserts (%0d evictions), %0d rejected by size, incl. a hot-line phase",
             n_inserts, n_evicts, n_rejects);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    repeat (200_000) @(posedge clk);
    $display("Timeout with %0d transactions outstanding", predicted_responses.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
